@@ hw/rtl/stq_pkg.sv @@
package stq_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int HANDLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int CMD_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_ADJUST = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EXPIRED  = 3'd1,
        ST_NONE     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4,
        ST_DUP      = 3'd5
    } status_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   expiry;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SHUP_RD,
        S_SHUP_WR,
        S_SHDN_RD,
        S_SHDN_WR,
        S_TICK_RD,
        S_TICK_EV,
        S_REPLY
    } state_t;

endpackage

@@ hw/rtl/sorted_expiry_timer_queue_top.sv @@
// Sorted timer list in one memory with a registered read; one command in flight at a time.
// An add scans for its slot and shifts later entries up; a duplicate add stops at the match;
// a full add replies without a scan; delete shifts later entries down; adjust deletes, then adds.
// Tick reports the expired entries from the head, last beat flagged, then compacts the list.
// s_tready is high again the cycle after a command ends; a wait on m_tready stalls the command.
// Reset (aresetn low, synchronous) empties the list and drops any pending result beat.
module sorted_expiry_timer_queue_top #(
    parameter int CAPACITY = stq_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] handle, [47:16] expire_at, [79:48] now_time
    input  logic [79:0]                   s_tdata,
    // [1:0] cmd
    input  logic [stq_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] out_handle
    output logic [stq_pkg::HANDLE_W-1:0]  m_tdata,
    // [2:0] status
    output logic [stq_pkg::STATUS_W-1:0]  m_tuser,
    output logic                          m_tlast
);
    import stq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    entry_t mem [CAPACITY];
    entry_t rdata_reg;
    logic   rd_en;
    logic   [AW-1:0] rd_addr;
    logic   wr_en;
    logic   [AW-1:0] wr_addr;
    entry_t wr_data;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [TIME_W-1:0]   exp_reg, exp_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] gap_reg, gap_next;
    logic          pos_set_reg, pos_set_next;
    logic          ins_reg, ins_next;
    status_t       rep_reg, rep_next;
    logic          pend_reg, pend_next;
    logic [HANDLE_W-1:0] pend_h_reg, pend_h_next;

    logic          m_valid_reg, m_valid_next;
    status_t       m_status_reg;
    logic [HANDLE_W-1:0] m_handle_reg;
    logic          m_last_reg;

    logic          emit;
    status_t       e_status;
    logic [HANDLE_W-1:0] e_handle;
    logic          e_last;
    logic          slot_free;
    logic [CW-1:0] src_idx;
    logic          in_acc;

    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign src_idx   = idx_reg + gap_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_handle_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        handle_reg  <= handle_next;
        exp_reg     <= exp_next;
        now_reg     <= now_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        gap_reg     <= gap_next;
        pos_set_reg <= pos_set_next;
        ins_reg     <= ins_next;
        rep_reg     <= rep_next;
        pend_h_reg  <= pend_h_next;
        if (emit) begin
            m_status_reg <= e_status;
            m_handle_reg <= e_handle;
            m_last_reg   <= e_last;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        handle_next  = handle_reg;
        exp_next     = exp_reg;
        now_next     = now_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        gap_next     = gap_reg;
        pos_set_next = pos_set_reg;
        ins_next     = ins_reg;
        rep_next     = rep_reg;
        pend_next    = pend_reg;
        pend_h_next  = pend_h_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = idx_reg[AW-1:0];
        wr_data      = rdata_reg;
        emit         = 1'b0;
        e_status     = rep_reg;
        e_handle     = handle_reg;
        e_last       = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    cmd_next     = cmd_t'(s_tuser);
                    handle_next  = s_tdata[15:0];
                    exp_next     = s_tdata[47:16];
                    now_next     = s_tdata[79:48];
                    idx_next     = '0;
                    pos_set_next = 1'b0;
                    pend_next    = 1'b0;
                    case (cmd_t'(s_tuser))
                        CMD_ADD: begin
                            ins_next = 1'b1;
                            if (cnt_reg == CW'(CAPACITY)) begin
                                rep_next   = ST_FULL;
                                state_next = S_REPLY;
                            end else begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        CMD_DELETE, CMD_ADJUST: begin
                            ins_next   = 1'b0;
                            state_next = S_SCAN_RD;
                        end
                        default: begin
                            state_next = S_TICK_RD;
                        end
                    endcase
                end
            end

            S_SCAN_RD: begin
                if (idx_reg < cnt_reg) begin
                    rd_en      = 1'b1;
                    state_next = S_SCAN_EV;
                end else if (ins_reg) begin
                    pos_next   = pos_set_reg ? pos_reg : cnt_reg;
                    idx_next   = cnt_reg;
                    state_next = S_SHUP_RD;
                end else begin
                    rep_next   = ST_NOTFOUND;
                    state_next = S_REPLY;
                end
            end

            S_SCAN_EV: begin
                if (rdata_reg.handle == handle_reg) begin
                    if (ins_reg) begin
                        rep_next   = ST_DUP;
                        state_next = S_REPLY;
                    end else begin
                        gap_next   = CW'(1);
                        state_next = S_SHDN_RD;
                    end
                end else begin
                    // first entry not earlier than the new expiry is the slot
                    if (!pos_set_reg && rdata_reg.expiry >= exp_reg) begin
                        pos_next     = idx_reg;
                        pos_set_next = 1'b1;
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_SHUP_RD: begin
                if (idx_reg > pos_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(idx_reg - CW'(1));
                    state_next = S_SHUP_WR;
                end else begin
                    wr_en        = 1'b1;
                    wr_data.handle = handle_reg;
                    wr_data.expiry = exp_reg;
                    cnt_next     = cnt_reg + CW'(1);
                    rep_next     = ST_OK;
                    state_next   = S_REPLY;
                end
            end

            S_SHUP_WR: begin
                wr_en      = 1'b1;
                idx_next   = idx_reg - CW'(1);
                state_next = S_SHUP_RD;
            end

            S_SHDN_RD: begin
                if (src_idx < cnt_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = src_idx[AW-1:0];
                    state_next = S_SHDN_WR;
                end else begin
                    cnt_next = cnt_reg - gap_reg;
                    case (cmd_reg)
                        CMD_ADJUST: begin
                            // reinsert under the new expiry
                            ins_next     = 1'b1;
                            idx_next     = '0;
                            pos_set_next = 1'b0;
                            state_next   = S_SCAN_RD;
                        end
                        CMD_DELETE: begin
                            rep_next   = ST_OK;
                            state_next = S_REPLY;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SHDN_WR: begin
                wr_en      = 1'b1;
                idx_next   = idx_reg + CW'(1);
                state_next = S_SHDN_RD;
            end

            S_TICK_RD: begin
                if (idx_reg < cnt_reg) begin
                    rd_en      = 1'b1;
                    state_next = S_TICK_EV;
                end else if (slot_free) begin
                    emit       = 1'b1;
                    e_status   = pend_reg ? ST_EXPIRED : ST_NONE;
                    e_handle   = pend_reg ? pend_h_reg : '0;
                    gap_next   = idx_reg;
                    idx_next   = '0;
                    state_next = S_SHDN_RD;
                end
            end

            S_TICK_EV: begin
                if (rdata_reg.expiry < now_reg) begin
                    // hold the previous expired handle until its last flag is known
                    if (!pend_reg || slot_free) begin
                        emit        = pend_reg;
                        e_status    = ST_EXPIRED;
                        e_handle    = pend_h_reg;
                        e_last      = 1'b0;
                        pend_next   = 1'b1;
                        pend_h_next = rdata_reg.handle;
                        idx_next    = idx_reg + CW'(1);
                        state_next  = S_TICK_RD;
                    end
                end else if (slot_free) begin
                    emit       = 1'b1;
                    e_status   = pend_reg ? ST_EXPIRED : ST_NONE;
                    e_handle   = pend_reg ? pend_h_reg : '0;
                    gap_next   = idx_reg;
                    idx_next   = '0;
                    state_next = S_SHDN_RD;
                end
            end

            S_REPLY: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

@@ bench/tb_sorted_expiry_timer_queue_top.sv @@
`timescale 1ns / 1ps

module tb_sorted_expiry_timer_queue_top;
    import stq_pkg::*;

    localparam int DEPTH          = CAPACITY_DEF;
    localparam int SETTLE_CYCLES  = 4 * DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF       = 300;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [79:0]           s_tdata  = '0;
    logic [CMD_W-1:0]      s_tuser  = CMD_ADD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [HANDLE_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    sorted_expiry_timer_queue_top #(
        .CAPACITY(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    typedef struct {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } reply_t;

    // Mirror of the sorted timer list, updated as each command beat is accepted
    logic [TIME_W-1:0]   tl_expiry [DEPTH];
    logic [HANDLE_W-1:0] tl_handle [DEPTH];
    int                  tl_count = 0;
    reply_t              expected_replies [$];

    int                  errors = 0;
    int                  tx_max_gap = 13;
    int                  rx_max_stall = 13;
    int                  rx_hold_cycles = 0;
    logic [TIME_W-1:0]   cur_time;

    function automatic int tl_find(logic [HANDLE_W-1:0] h);
        for (int i = 0; i < tl_count; i++)
            if (tl_handle[i] == h)
                return i;
        return -1;
    endfunction

    function automatic void tl_remove(int pos);
        for (int i = pos; i + 1 < tl_count; i++) begin
            tl_expiry[i] = tl_expiry[i + 1];
            tl_handle[i] = tl_handle[i + 1];
        end
        tl_count--;
    endfunction

    // New entry goes ahead of any entry with the same expiry
    function automatic void tl_insert(logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] exp);
        int pos;
        pos = 0;
        while (pos < tl_count && tl_expiry[pos] < exp)
            pos++;
        for (int i = tl_count; i > pos; i--) begin
            tl_expiry[i] = tl_expiry[i - 1];
            tl_handle[i] = tl_handle[i - 1];
        end
        tl_expiry[pos] = exp;
        tl_handle[pos] = h;
        tl_count++;
    endfunction

    function automatic void push_reply(status_t st, logic [HANDLE_W-1:0] h, logic last);
        reply_t r;
        r.status = st;
        r.handle = h;
        r.last   = last;
        expected_replies.push_back(r);
    endfunction

    function automatic void tl_apply(cmd_t c, logic [HANDLE_W-1:0] h,
                                     logic [TIME_W-1:0] exp, logic [TIME_W-1:0] now);
        int pos;
        int n;
        case (c)
            CMD_ADD: begin
                if (tl_count >= DEPTH)
                    push_reply(ST_FULL, h, 1'b1);
                else if (tl_find(h) >= 0)
                    push_reply(ST_DUP, h, 1'b1);
                else begin
                    tl_insert(h, exp);
                    push_reply(ST_OK, h, 1'b1);
                end
            end
            CMD_DELETE, CMD_ADJUST: begin
                pos = tl_find(h);
                if (pos < 0)
                    push_reply(ST_NOTFOUND, h, 1'b1);
                else begin
                    tl_remove(pos);
                    if (c == CMD_ADJUST)
                        tl_insert(h, exp);
                    push_reply(ST_OK, h, 1'b1);
                end
            end
            default: begin
                n = 0;
                while (tl_count > 0 && tl_expiry[0] < now) begin
                    push_reply(ST_EXPIRED, tl_handle[0], 1'b0);
                    tl_remove(0);
                    n++;
                end
                if (n == 0)
                    push_reply(ST_NONE, '0, 1'b1);
                else
                    expected_replies[expected_replies.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    // Small handle pool so duplicates and hits are common; some fully random
    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 9) == 0)
            return HANDLE_W'($urandom);
        return ($urandom_range(0, 1) ? 16'hA500 : 16'h5A00) | 16'($urandom_range(0, 23));
    endfunction

    function automatic logic [TIME_W-1:0] pick_expiry();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return cur_time + $urandom_range(0, 400);
        if (r < 95)
            return $urandom;
        return (r < 97) ? 32'h0 : 32'hFFFF_FFFF;
    endfunction

    function automatic logic [TIME_W-1:0] pick_now();
        int r;
        r = $urandom_range(0, 99);
        cur_time = cur_time + $urandom_range(0, 60);
        if (r < 80)
            return cur_time + $urandom_range(0, 120);
        if (r < 90)
            return $urandom;
        return (r < 95) ? 32'h0 : 32'hFFFF_FFFF;
    endfunction

    // Offer one command beat; keep tvalid high across back-to-back beats
    task automatic send_timer_cmd(input cmd_t c, input logic [HANDLE_W-1:0] h,
                                  input logic [TIME_W-1:0] exp,
                                  input logic [TIME_W-1:0] now);
        int gap;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {now, exp, h};
        do @(posedge aclk); while (!s_tready);
        tl_apply(c, h, exp, now);
    endtask

    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_directed_ops();
        send_timer_cmd(CMD_TICK,   16'h1234, 32'h0, 32'h10);         // empty list
        send_timer_cmd(CMD_DELETE, 16'h0042, 32'h0, 32'h0);          // unknown handle
        send_timer_cmd(CMD_ADJUST, 16'h0042, 32'h5, 32'h0);
        send_timer_cmd(CMD_ADD,    16'h0000, 32'hFFFF_FFFF, 32'h0);
        send_timer_cmd(CMD_ADD,    16'hFFFF, 32'h0, 32'hFFFF_FFFF);
        send_timer_cmd(CMD_ADD,    16'h0005, 32'd100, 32'h0);
        send_timer_cmd(CMD_ADD,    16'h0006, 32'd100, 32'h0);        // ties go first
        send_timer_cmd(CMD_ADD,    16'h0005, 32'd7, 32'h0);          // duplicate
        send_timer_cmd(CMD_TICK,   16'h0, 32'h0, 32'h0);             // nothing below zero
        send_timer_cmd(CMD_ADJUST, 16'hFFFF, 32'd100, 32'h0);        // later, ahead of ties
        send_timer_cmd(CMD_ADJUST, 16'h0000, 32'd50, 32'h0);         // earlier
        send_timer_cmd(CMD_DELETE, 16'h0006, 32'h0, 32'h0);
        send_timer_cmd(CMD_TICK,   16'hFFFF, 32'hFFFF_FFFF, 32'd100);
        send_timer_cmd(CMD_TICK,   16'h0, 32'h0, 32'd100);           // equal is not expired
        send_timer_cmd(CMD_TICK,   16'h0, 32'h0, 32'd101);
        send_timer_cmd(CMD_TICK,   16'h0, 32'h0, 32'hFFFF_FFFF);
        wait_for_replies();
    endtask

    task automatic test_full_queue();
        logic [HANDLE_W-1:0] h;
        send_timer_cmd(CMD_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);
        while (tl_count > 0)
            send_timer_cmd(CMD_DELETE, tl_handle[0], $urandom, $urandom);
        for (int i = 0; i < DEPTH; i++)
            send_timer_cmd(CMD_ADD, 16'hC000 | 16'(i),
                           i[0] ? $urandom_range(1000, 1007) : $urandom_range(0, 32'hFFFF_FFFE),
                           $urandom);
        send_timer_cmd(CMD_ADD, 16'h7FFF, 32'd5, 32'h0);             // no room
        send_timer_cmd(CMD_ADD, 16'hC003, 32'd5, 32'h0);             // full wins over duplicate
        send_timer_cmd(CMD_DELETE, 16'h7FFF, 32'h0, 32'h0);
        h = tl_handle[$urandom_range(0, DEPTH - 1)];
        send_timer_cmd(CMD_ADJUST, h, 32'd3, 32'h0);                 // full list, re-sort
        send_timer_cmd(CMD_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);       // drains every entry
        send_timer_cmd(CMD_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);
        wait_for_replies();
    endtask

    task automatic test_random_traffic(input int n_items);
        int r;
        logic [HANDLE_W-1:0] h;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_timer_cmd(CMD_ADD, pick_handle(), pick_expiry(), $urandom);
            else if (r < 75) begin
                if (tl_count > 0 && $urandom_range(0, 3) != 0)
                    h = tl_handle[$urandom_range(0, tl_count - 1)];
                else
                    h = pick_handle();
                send_timer_cmd((r < 55) ? CMD_DELETE : CMD_ADJUST, h, pick_expiry(), $urandom);
            end else
                send_timer_cmd(CMD_TICK, HANDLE_W'($urandom), $urandom, pick_now());
        end
        wait_for_replies();
    endtask

    // Result side stalls long enough for the command side to back up
    task automatic test_backpressure();
        tx_max_gap = 0;
        rx_hold_cycles = HOLD_OFF;
        for (int k = 0; k < 24; k++)
            send_timer_cmd((k % 6 == 5) ? CMD_TICK : CMD_ADD, pick_handle(), pick_expiry(),
                           pick_now());
        wait_for_replies();
        tx_max_gap = 13;
    endtask

    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end else begin
                stall = (rx_max_stall == 0) ? 0 : $urandom_range(0, rx_max_stall);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : check_reply
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, got status %0d handle %h",
                         $time, m_tuser, m_tdata);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                if (m_tuser !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, m_tuser);
                    errors++;
                end
                if (m_tdata !== want.handle) begin
                    $display("%0t: handle mismatch: expected %h, got %h",
                             $time, want.handle, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: tlast mismatch: expected %b, got %b",
                             $time, want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_sorted_expiry_timer_queue_top failed");
        $finish;
    end

    initial begin
        cur_time = $urandom;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_ops();
        test_random_traffic(60);
        tx_max_gap   = 0;
        rx_max_stall = 0;
        test_random_traffic(40);
        tx_max_gap   = 13;
        rx_max_stall = 13;
        test_full_queue();
        test_backpressure();
        test_random_traffic(80);
        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_replies.size() == 0)
            $display("tb_sorted_expiry_timer_queue_top passed");
        else
            $display("tb_sorted_expiry_timer_queue_top failed");
        $finish;
    end

endmodule
